[hdl/ostt_pkg.sv]
// Package of shared constants, opcodes and control structs for the one-shot timer table.
`default_nettype none

package ostt_pkg;

  // Table size and the width of a slot index.
  localparam int NUM_SLOTS = 64;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int PAR_W  = 32;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted item and rewind the scan
    logic step;    // apply the current slot's action and move on
    logic finish;  // emit the closing result and commit a start
  } ostt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_out;   // current slot emits an earlier expiry, needs the output register
    logic out_free;   // output register can be loaded this cycle
    logic last_slot;  // scan pointer is on the final slot
  } ostt_sts_t;

endpackage : ostt_pkg

`default_nettype wire

[hdl/ostt_ctrl.sv]
// Controller state machine sequencing the slot scan for each item.
`default_nettype none

module ostt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ostt_pkg::ostt_sts_t sts,
  output ostt_pkg::ostt_cmd_t    cmd
);
  import ostt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load   = in_valid && (state_r == ST_IDLE);
    cmd.step   = (state_r == ST_SCAN) && (!sts.need_out || sts.out_free);
    cmd.finish = (state_r == ST_FINISH) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd.step && sts.last_slot) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd.finish) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one command is issued in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.step, cmd.finish}) <= 1)
    else $error("more than one command in a cycle");

  // Loading an item always starts a scan.
  a_load_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SCAN)
    else $error("load did not start a scan");

  // The closing result is followed by a return to idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("block not idle after finishing an item");

endmodule : ostt_ctrl

`default_nettype wire

[hdl/ostt_datapath.sv]
// Datapath: slot memory, valid bits, scan pointer, match logic and output register.
`default_nettype none

module ostt_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ostt_pkg::ostt_cmd_t          cmd,
  output ostt_pkg::ostt_sts_t               sts,
  input  wire logic [ostt_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [ostt_pkg::ID_W-1:0]    in_timer_id,
  input  wire logic [ostt_pkg::TIME_W-1:0]  in_duration_ms,
  input  wire logic [ostt_pkg::PAR_W-1:0]   in_user_param,
  input  wire logic [ostt_pkg::TIME_W-1:0]  in_now_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_fired,
  output logic [ostt_pkg::ID_W-1:0]         out_fired_id,
  output logic [ostt_pkg::PAR_W-1:0]        out_fired_param,
  output logic                              out_running,
  output logic                              out_accepted,
  output logic                              out_last
);
  import ostt_pkg::*;

  localparam int ENTRY_W = ID_W + TIME_W + TIME_W + PAR_W;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] duration;
    logic [PAR_W-1:0]  param;
  } slot_entry_t;

  // Slot memory: one write port, one registered read port.
  logic [ENTRY_W-1:0] slot_mem [NUM_SLOTS];
  slot_entry_t        rd_q;
  logic [SLOT_AW-1:0] rd_addr;
  logic               mem_we;
  slot_entry_t        wr_data;

  // Captured item.
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] dur_r;
  logic [PAR_W-1:0]  par_r;
  logic [TIME_W-1:0] now_r;

  // Scan control.
  logic [SLOT_AW-1:0]   ptr_r, ptr_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_AW-1:0]   target_r, target_nxt;
  logic [NUM_SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  // Expiry held back until it is known whether it is the final one.
  logic              pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [PAR_W-1:0]  pend_param_r, pend_param_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [PAR_W-1:0]  out_param_r, out_param_nxt;
  logic              out_running_r, out_running_nxt;
  logic              out_accepted_r, out_accepted_nxt;
  logic              out_last_r, out_last_nxt;

  logic              cur_valid;
  logic              cur_match;
  logic              cur_expired;
  logic [TIME_W-1:0] elapsed;
  logic              last_slot;
  logic              out_free;
  logic              out_load;

  assign cur_valid   = slot_valid_r[ptr_r];
  assign cur_match   = cur_valid && (rd_q.id == id_r);
  assign elapsed     = now_r - rd_q.start;
  assign cur_expired = cur_valid && (elapsed >= rd_q.duration);
  assign last_slot   = (ptr_r == SLOT_AW'(NUM_SLOTS - 1));
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    sts.need_out  = (op_r == OP_PROCESS) && cur_expired && pend_valid_r;
    sts.out_free  = out_free;
    sts.last_slot = last_slot;
  end

  // Read address follows the pointer so that rd_q always holds slot ptr_r.
  always_comb begin
    if (cmd.load) begin
      rd_addr = '0;
    end else if (cmd.step && !last_slot) begin
      rd_addr = ptr_r + SLOT_AW'(1);
    end else begin
      rd_addr = ptr_r;
    end
  end

  assign mem_we           = cmd.finish && (op_r == OP_START) && found_r;
  assign wr_data.id       = id_r;
  assign wr_data.start    = now_r;
  assign wr_data.duration = dur_r;
  assign wr_data.param    = par_r;

  always_comb begin
    ptr_nxt        = ptr_r;
    found_nxt      = found_r;
    target_nxt     = target_r;
    slot_valid_nxt = slot_valid_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_param_nxt = pend_param_r;
    out_load       = 1'b0;

    if (cmd.load) begin
      ptr_nxt        = '0;
      found_nxt      = 1'b0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.step) begin
      if (!last_slot) ptr_nxt = ptr_r + SLOT_AW'(1);
      case (op_r)
        OP_PROCESS: begin
          if (cur_expired) begin
            slot_valid_nxt[ptr_r] = 1'b0;
            out_load       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_q.id;
            pend_param_nxt = rd_q.param;
          end
        end
        OP_START: begin
          if (!found_r && (!cur_valid || cur_match)) begin
            found_nxt  = 1'b1;
            target_nxt = ptr_r;
          end else if (found_r && cur_match) begin
            slot_valid_nxt[ptr_r] = 1'b0;
          end
        end
        OP_CANCEL: begin
          if (!found_r && cur_match) begin
            found_nxt             = 1'b1;
            slot_valid_nxt[ptr_r] = 1'b0;
          end
        end
        OP_QUERY: begin
          if (cur_match) found_nxt = 1'b1;
        end
        default: begin
          found_nxt = found_r;
        end
      endcase
    end

    if (cmd.finish) begin
      out_load = 1'b1;
      if (mem_we) slot_valid_nxt[target_r] = 1'b1;
    end
  end

  // Output register contents.
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_fired_nxt    = out_fired_r;
    out_id_nxt       = out_id_r;
    out_param_nxt    = out_param_r;
    out_running_nxt  = out_running_r;
    out_accepted_nxt = out_accepted_r;
    out_last_nxt     = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (cmd.finish) begin
        out_fired_nxt    = (op_r == OP_PROCESS) && pend_valid_r;
        out_id_nxt       = out_fired_nxt ? pend_id_r : '0;
        out_param_nxt    = out_fired_nxt ? pend_param_r : '0;
        out_running_nxt  = (op_r == OP_QUERY) && found_r;
        out_accepted_nxt = (op_r == OP_START) && found_r;
        out_last_nxt     = 1'b1;
      end else begin
        out_fired_nxt    = 1'b1;
        out_id_nxt       = pend_id_r;
        out_param_nxt    = pend_param_r;
        out_running_nxt  = 1'b0;
        out_accepted_nxt = 1'b0;
        out_last_nxt     = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[target_r] <= wr_data;
    end
    rd_q <= slot_entry_t'(slot_mem[rd_addr]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      id_r  <= in_timer_id;
      dur_r <= in_duration_ms;
      par_r <= in_user_param;
      now_r <= in_now_ms;
    end
    target_r       <= target_nxt;
    pend_id_r      <= pend_id_nxt;
    pend_param_r   <= pend_param_nxt;
    out_fired_r    <= out_fired_nxt;
    out_id_r       <= out_id_nxt;
    out_param_r    <= out_param_nxt;
    out_running_r  <= out_running_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_last_r     <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      found_r      <= 1'b0;
      slot_valid_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ptr_r        <= ptr_nxt;
      found_r      <= found_nxt;
      slot_valid_r <= slot_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_fired_r;
  assign out_fired_id    = out_id_r;
  assign out_fired_param = out_param_r;
  assign out_running     = out_running_r;
  assign out_accepted    = out_accepted_r;
  assign out_last        = out_last_r;

  // The output register is never overwritten while it still holds an untaken item.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

  // A held-back expiry only exists while the captured item is a process item.
  a_pend_process: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (op_r == OP_PROCESS))
    else $error("pending expiry outside a process scan");

  // A committed start leaves its slot occupied.
  a_start_commits: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> slot_valid_r[$past(target_r)])
    else $error("started slot not marked valid");

endmodule : ostt_datapath

`default_nettype wire

[hdl/one_shot_timer_table_unit.sv]
// Top level of the one-shot timer table: controller and datapath joined by command and status.
//
//   Channel | Ports                                              | Direction
//   --------+----------------------------------------------------+----------
//   input   | in_valid, in_ready, in_opcode, in_timer_id,        | in
//           | in_duration_ms, in_user_param, in_now_ms           |
//   result  | out_valid, out_ready, out_fired, out_fired_id,     | out
//           | out_fired_param, out_running, out_accepted,        |
//           | out_last                                           |
//
// Each item is accepted, scanned slot by slot and then closed with a closing result
// in the output register. The scan is set by the single read port of the slot
// memory, which delivers one slot per cycle unless the scan pauses as below.
// Reset is synchronous and clears all valid bits at once; the slot memory needs
// no clearing pass, as an entry is only looked at while its valid bit is set.
// A process item holds back each expiry until the next one is found, so that
// the final result can carry last; the scan pauses only while the output
// register still holds an untaken item. A new item is taken once the previous
// one has been handed to the output register.
`default_nettype none

module one_shot_timer_table_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ostt_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [ostt_pkg::ID_W-1:0]    in_timer_id,
  input  wire logic [ostt_pkg::TIME_W-1:0]  in_duration_ms,
  input  wire logic [ostt_pkg::PAR_W-1:0]   in_user_param,
  input  wire logic [ostt_pkg::TIME_W-1:0]  in_now_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_fired,
  output logic [ostt_pkg::ID_W-1:0]         out_fired_id,
  output logic [ostt_pkg::PAR_W-1:0]        out_fired_param,
  output logic                              out_running,
  output logic                              out_accepted,
  output logic                              out_last
);
  import ostt_pkg::*;

  // Commands flow from the controller; status flows back from the datapath.
  ostt_cmd_t cmd;
  ostt_sts_t sts;

  // The controller decides when an item is taken, when the scan may advance
  // and when the closing result is written.
  ostt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the slots, evaluates one slot per cycle unless an untaken
  // result stalls the scan, and owns the output register.
  ostt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_timer_id     (in_timer_id),
    .in_duration_ms  (in_duration_ms),
    .in_user_param   (in_user_param),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fired       (out_fired),
    .out_fired_id    (out_fired_id),
    .out_fired_param (out_fired_param),
    .out_running     (out_running),
    .out_accepted    (out_accepted),
    .out_last        (out_last)
  );

endmodule : one_shot_timer_table_unit

`default_nettype wire
